// ===== rtl/core/mlfc_pkg.sv =====
package mlfc_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned WordW    = 16;
  localparam int unsigned CountW   = 17;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned OutDataW = 64;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [CountW-1:0] MinFrame = CountW'(10);
  localparam logic [CountW-1:0] HdrBytes = CountW'(6);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEAD_MARKER = 1'b0,
    CFG_TAIL_MARKER = 1'b1
  } cfg_idx_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_BAD_HEAD = 3'd2,
    ST_LEN_MISM = 3'd3,
    ST_BAD_TAIL = 3'd4
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_t;

endpackage

// ===== rtl/core/marker_length_frame_checker_core.sv =====
// Byte-stream frame checker. Each request is one received byte, with in_tlast on the
// final byte of the buffer. Frames are: head marker (2 bytes), command (2), payload
// length (2), payload, 2 unchecked CRC bytes, tail marker (2), all high byte first.
// Payload bytes leave as tentative results (out_tuser = 0) while they arrive; the final
// byte yields one verdict (out_tuser = 1): short, bad head, length mismatch, bad
// tail or ok, in that order of priority, and the frame state is cleared. One byte is
// taken every clock while the output is not stalled: the byte counter and compares
// sit between the input and a single output register, and a new byte is taken while
// a result waits as long as that register is being emptied in the same cycle.
// The user must write markers through cfg_* while the stream is idle; not enforced.
module marker_length_frame_checker_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [mlfc_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [mlfc_pkg::WordW-1:0]       cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [mlfc_pkg::ByteW-1:0]       in_tdata,   // rx_byte
  input  logic                             in_tlast,   // end_of_buffer
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // payload_byte[7:0], payload_index[23:8], command[39:24],
  // payload_length[55:40], status[58:56], zero fill[63:59]
  output logic [mlfc_pkg::OutDataW-1:0]    out_tdata,
  output logic                             out_tuser   // kind
);

  localparam int unsigned CW = mlfc_pkg::CountW;
  localparam int unsigned WW = mlfc_pkg::WordW;
  localparam int unsigned BW = mlfc_pkg::ByteW;

  logic [WW-1:0] head_marker_r, tail_marker_r;
  logic [CW-1:0] byte_count_r, byte_count_nxt;
  logic          head_bad_r, head_bad_nxt;
  logic [WW-1:0] command_word_r, command_word_nxt;
  logic [WW-1:0] declared_length_r, declared_length_nxt;
  logic [BW-1:0] previous_byte_r;

  logic                         out_valid_r;
  logic [mlfc_pkg::OutDataW-1:0] out_data_r;
  logic                         out_kind_r;

  logic                  accept;
  logic [BW-1:0]         b;
  logic [CW-1:0]         pos, total;
  logic [CW:0]           payload_end, frame_len;
  logic                  in_payload;
  logic                  has_result;
  mlfc_pkg::status_t     status;
  logic [WW-1:0]         cmd_out, len_out;
  logic [WW-1:0]         pidx;
  logic [CW-1:0]         pidx_full;
  logic [mlfc_pkg::OutDataW-1:0] data_nxt;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign b          = in_tdata;
  assign pos        = byte_count_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

  always_comb begin
    head_bad_nxt        = head_bad_r;
    command_word_nxt    = command_word_r;
    declared_length_nxt = declared_length_r;
    if (pos == CW'(0) && b != head_marker_r[15:8]) head_bad_nxt = 1'b1;
    if (pos == CW'(1) && b != head_marker_r[7:0])  head_bad_nxt = 1'b1;
    if (pos == CW'(2)) command_word_nxt[15:8]    = b;
    if (pos == CW'(3)) command_word_nxt[7:0]     = b;
    if (pos == CW'(4)) declared_length_nxt[15:8] = b;
    if (pos == CW'(5)) declared_length_nxt[7:0]  = b;
  end

  assign total       = (pos != mlfc_pkg::CountMax) ? pos + CW'(1) : mlfc_pkg::CountMax;
  assign payload_end = {1'b0, mlfc_pkg::HdrBytes} + (CW+1)'(declared_length_nxt);
  assign frame_len   = {1'b0, mlfc_pkg::MinFrame} + (CW+1)'(declared_length_nxt);
  assign in_payload  = !head_bad_nxt && (pos >= mlfc_pkg::HdrBytes)
                       && ({1'b0, pos} < payload_end);
  assign has_result  = in_tlast || in_payload;
  assign pidx_full   = pos - mlfc_pkg::HdrBytes;
  assign pidx        = pidx_full[WW-1:0];

  always_comb begin
    if (total < mlfc_pkg::MinFrame) begin
      status = mlfc_pkg::ST_SHORT;
    end else if (head_bad_nxt) begin
      status = mlfc_pkg::ST_BAD_HEAD;
    end else if ({1'b0, total} != frame_len) begin
      status = mlfc_pkg::ST_LEN_MISM;
    end else if (previous_byte_r != tail_marker_r[15:8] || b != tail_marker_r[7:0]) begin
      status = mlfc_pkg::ST_BAD_TAIL;
    end else begin
      status = mlfc_pkg::ST_OK;
    end
  end

  always_comb begin
    cmd_out = command_word_nxt;
    len_out = declared_length_nxt;
    if (status == mlfc_pkg::ST_SHORT || status == mlfc_pkg::ST_BAD_HEAD) begin
      cmd_out = '0;
      len_out = '0;
    end
    data_nxt = '0;
    if (in_tlast) begin
      data_nxt[39:24] = cmd_out;
      data_nxt[55:40] = len_out;
      data_nxt[58:56] = status;
    end else begin
      data_nxt[7:0]   = b;
      data_nxt[23:8]  = pidx;
      data_nxt[39:24] = command_word_nxt;
      data_nxt[55:40] = declared_length_nxt;
    end
  end

  assign byte_count_nxt = in_tlast ? '0 : total;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_marker_r <= '0;
      tail_marker_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mlfc_pkg::CFG_HEAD_MARKER: head_marker_r <= cfg_wdata;
        mlfc_pkg::CFG_TAIL_MARKER: tail_marker_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r      <= '0;
      head_bad_r        <= 1'b0;
      command_word_r    <= '0;
      declared_length_r <= '0;
      previous_byte_r   <= '0;
    end else if (accept) begin
      byte_count_r      <= byte_count_nxt;
      head_bad_r        <= in_tlast ? 1'b0 : head_bad_nxt;
      command_word_r    <= in_tlast ? '0 : command_word_nxt;
      declared_length_r <= in_tlast ? '0 : declared_length_nxt;
      previous_byte_r   <= in_tlast ? '0 : b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && has_result) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_result) begin
      out_data_r <= data_nxt;
      out_kind_r <= in_tlast ? mlfc_pkg::KIND_VERDICT : mlfc_pkg::KIND_PAYLOAD;
    end
  end

endmodule
